// ===== src/mopf_pkg.sv =====
// Shared types, codes and the init command table for the page-mode frame buffer.
// Used by every module of the block; depends on nothing.
package mopf_pkg;

    // Action codes as they arrive on the input stream.
    localparam logic [2:0] ACT_PIXEL   = 3'd0;
    localparam logic [2:0] ACT_CLEAR   = 3'd1;
    localparam logic [2:0] ACT_ROW     = 3'd2;
    localparam logic [2:0] ACT_INIT    = 3'd3;
    localparam logic [2:0] ACT_REFRESH = 3'd4;
    localparam logic [2:0] ACT_FETCH   = 3'd5;

    // Operations handed from the front end to the back end.
    localparam logic [2:0] OP_NONE    = 3'd0;
    localparam logic [2:0] OP_PIXEL   = 3'd1;
    localparam logic [2:0] OP_CLEAR   = 3'd2;
    localparam logic [2:0] OP_ROW     = 3'd3;
    localparam logic [2:0] OP_INIT    = 3'd4;
    localparam logic [2:0] OP_REFRESH = 3'd5;
    localparam logic [2:0] OP_FETCH   = 3'd6;

    // Stream phases.
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_INIT    = 2'd1;
    localparam logic [1:0] PH_REFRESH = 2'd2;

    localparam int         INIT_LEN       = 25;
    localparam logic [4:0] CONTRAST_SLOT  = 5'd17;
    localparam logic [7:0] CONTRAST_RESET = 8'd127;

    localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [7:0] CMD_COL_LO    = 8'h00;
    localparam logic [7:0] CMD_COL_HI    = 8'h10;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] x;
        logic [3:0] page;
        logic [7:0] mask;
        logic       on;
    } cmd_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       is_data;
        logic       last;
        logic       busy;
    } res_t;

    function automatic logic [7:0] init_byte(input logic [4:0] idx);
        logic [7:0] b;
        case (idx)
            5'd0:    b = 8'hAE;
            5'd1:    b = 8'hD5;
            5'd2:    b = 8'h80;
            5'd3:    b = 8'hA8;
            5'd4:    b = 8'h3F;
            5'd5:    b = 8'hD3;
            5'd6:    b = 8'h00;
            5'd7:    b = 8'h40;
            5'd8:    b = 8'h8D;
            5'd9:    b = 8'h14;
            5'd10:   b = 8'h20;
            5'd11:   b = 8'h02;
            5'd12:   b = 8'hA1;
            5'd13:   b = 8'hC8;
            5'd14:   b = 8'hDA;
            5'd15:   b = 8'h12;
            5'd16:   b = 8'h81;
            5'd17:   b = 8'h7F;
            5'd18:   b = 8'hD9;
            5'd19:   b = 8'hF1;
            5'd20:   b = 8'hDB;
            5'd21:   b = 8'h40;
            5'd22:   b = 8'hA4;
            5'd23:   b = 8'hA6;
            5'd24:   b = 8'hAF;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== src/mono_oled_page_framebuffer.sv =====
// Top level of the page-mode monochrome OLED frame buffer.
// Depends on mopf_pkg, mopf_front, mopf_queue and mopf_back.

// Frame buffer of COLUMNS x (PAGE_COUNT*8) pixels kept as pages of column bytes in one
// single-port memory, with the display byte stream produced one byte per fetch request.
// Every input request gives exactly one result. Requests are decoded on entry and wait in
// a two-entry queue, so the input keeps accepting while a result waits on the output.
// At the head of the queue, start, out-of-range and command-byte requests are answered
// straight from the idle state; a pixel or a data-byte fetch reads the memory, then writes
// or delivers; a row line reads and writes each column of its page, and a clear writes
// every byte. The last init byte is followed by a clearing sweep of the whole memory.
// After reset the memory is cleared in a pass over all COLUMNS*PAGE_COUNT bytes (1024 by
// default) during which no request is accepted; the contrast register can be written at
// any idle time, including during that pass.
module mono_oled_page_framebuffer #(
    parameter int COLUMNS    = 128,
    parameter int PAGE_COUNT = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,   // contrast_level[7:0]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // pixel_x[7:0], pixel_y[14:8], pixel_on[15]
    input  logic [2:0]  s_tuser,    // action[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // out_valid[0], out_byte[8:1], stream_busy[9], zero
    output logic        m_tuser,    // out_is_data
    output logic        m_tlast     // out_last
);
    import mopf_pkg::*;

    logic push;
    logic q_full;
    logic q_valid;
    logic q_pop;
    logic booting;
    cmd_t f_cmd;
    cmd_t q_cmd;
    res_t res;

    assign cfg_ready = 1'b1;

    mopf_front #(
        .COLUMNS    (COLUMNS),
        .PAGE_COUNT (PAGE_COUNT)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .booting  (booting),
        .push     (push),
        .cmd      (f_cmd)
    );

    mopf_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .cmd_in  (f_cmd),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .cmd_out (q_cmd)
    );

    mopf_back #(
        .COLUMNS    (COLUMNS),
        .PAGE_COUNT (PAGE_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .booting   (booting),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_res     (res)
    );

    assign m_tdata = {6'd0, res.busy, res.data_byte, res.valid};
    assign m_tuser = res.is_data;
    assign m_tlast = res.last;

    // The back end only takes from the queue when something is there.
    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // A request pushed into an otherwise untouched queue is there next cycle.
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        push && !q_pop |=> q_valid)
        else $error("pushed request missing from queue");

    // A data byte is always a delivered byte.
    a_data_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[0])
        else $error("data flag without a stream byte");

    // The final byte of a stream is a data byte and leaves the stream idle.
    a_last_ends_stream: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser && !m_tdata[9])
        else $error("last byte not a data byte or stream still busy");

endmodule

// ===== src/mopf_front.sv =====
// Front end: takes input requests, checks bounds and turns them into back-end operations.
// Depends on mopf_pkg.
module mopf_front #(
    parameter int COLUMNS    = 128,
    parameter int PAGE_COUNT = 8
) (
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [15:0]    s_tdata,   // pixel_x[7:0], pixel_y[14:8], pixel_on[15]
    input  logic [2:0]     s_tuser,   // action[2:0]
    input  logic           q_full,
    input  logic           booting,
    output logic           push,
    output mopf_pkg::cmd_t cmd
);
    import mopf_pkg::*;

    localparam logic [8:0] COL_LIMIT = 9'(COLUMNS);
    localparam logic [7:0] ROW_LIMIT = 8'(PAGE_COUNT * 8);

    logic [7:0] px;
    logic [6:0] py;
    logic       x_ok;
    logic       y_ok;

    assign px   = s_tdata[7:0];
    assign py   = s_tdata[14:8];
    assign x_ok = {1'b0, px} < COL_LIMIT;
    assign y_ok = {1'b0, py} < ROW_LIMIT;

    assign s_tready = !q_full && !booting;
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        cmd.x    = px;
        cmd.page = py[6:3];
        cmd.mask = 8'd1 << py[2:0];
        cmd.on   = s_tdata[15];
        case (s_tuser)
            ACT_PIXEL:   cmd.op = (x_ok && y_ok) ? OP_PIXEL : OP_NONE;
            ACT_CLEAR:   cmd.op = OP_CLEAR;
            ACT_ROW:     cmd.op = y_ok ? OP_ROW : OP_NONE;
            ACT_INIT:    cmd.op = OP_INIT;
            ACT_REFRESH: cmd.op = OP_REFRESH;
            ACT_FETCH:   cmd.op = OP_FETCH;
            default:     cmd.op = OP_NONE;
        endcase
        // A row line starts at the first column of its page.
        if (s_tuser == ACT_ROW)
        begin
            cmd.x = 8'd0;
        end
    end

endmodule

// ===== src/mopf_queue.sv =====
// Two-entry operation queue between the front and back ends.
// Depends on mopf_pkg.
module mopf_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mopf_pkg::cmd_t cmd_in,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output mopf_pkg::cmd_t cmd_out
);
    import mopf_pkg::*;

    cmd_t       entries_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full    = count_reg == 2'd2;
    assign valid   = count_reg != 2'd0;
    assign cmd_out = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// ===== src/mopf_back.sv =====
// Back end: frame memory, stream sequencer and the result register.
// Depends on mopf_pkg.
module mopf_back #(
    parameter int COLUMNS    = 128,
    parameter int PAGE_COUNT = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_valid,
    input  logic [7:0]     cfg_data,
    input  logic           q_valid,
    input  mopf_pkg::cmd_t q_cmd,
    output logic           q_pop,
    output logic           booting,
    output logic           m_tvalid,
    input  logic           m_tready,
    output mopf_pkg::res_t m_res
);
    import mopf_pkg::*;

    localparam int STORE = COLUMNS * PAGE_COUNT;
    localparam int AW    = $clog2(STORE);
    localparam int CW    = $clog2(COLUMNS);
    localparam int OW_R  = $clog2(COLUMNS + 3);
    localparam int OW    = (OW_R > 5) ? OW_R : 5;
    localparam int PW    = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE - 1);
    localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
    localparam logic [OW-1:0] LAST_OFF  = OW'(COLUMNS + 2);
    localparam logic [OW-1:0] LAST_INIT = OW'(INIT_LEN - 1);
    localparam logic [OW-1:0] FIRST_DAT = OW'(3);
    localparam logic [PW-1:0] LAST_PAGE = PW'(PAGE_COUNT - 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_CLEAR    = 3'd1;
    localparam logic [2:0] S_PIX_RD   = 3'd2;
    localparam logic [2:0] S_PIX_WR   = 3'd3;
    localparam logic [2:0] S_ROW_RD   = 3'd4;
    localparam logic [2:0] S_ROW_WR   = 3'd5;
    localparam logic [2:0] S_FETCH_RD = 3'd6;
    localparam logic [2:0] S_FETCH_WR = 3'd7;

    logic [7:0]    frame_mem [STORE];
    logic [7:0]    rd_data_reg;
    logic          mem_we;
    logic [7:0]    mem_wd;

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [AW-1:0] addr_reg;
    logic [AW-1:0] addr_next;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    cmd_t          cur_reg;
    cmd_t          cur_next;
    logic          boot_reg;
    logic          boot_next;
    logic          clr_emit_reg;
    logic          clr_emit_next;
    logic [1:0]    phase_reg;
    logic [1:0]    phase_next;
    logic [OW-1:0] off_reg;
    logic [OW-1:0] off_next;
    logic [PW-1:0] page_reg;
    logic [PW-1:0] page_next;
    logic [7:0]    contrast_reg;
    logic          m_valid_reg;
    logic          m_valid_next;
    res_t          res_reg;

    logic          out_free;
    logic          emit;
    logic          adv;
    res_t          res;
    logic [AW-1:0] cmd_base;

    assign out_free = !m_valid_reg || m_tready;
    assign booting  = boot_reg;
    assign m_tvalid = m_valid_reg;
    assign m_res    = res_reg;
    assign cmd_base = AW'(int'(q_cmd.page) * COLUMNS + int'(q_cmd.x));

    always_comb
    begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        col_next      = col_reg;
        cur_next      = cur_reg;
        boot_next     = boot_reg;
        clr_emit_next = clr_emit_reg;
        phase_next    = phase_reg;
        off_next      = off_reg;
        page_next     = page_reg;
        q_pop         = 1'b0;
        mem_we        = 1'b0;
        mem_wd        = 8'd0;
        emit          = 1'b0;
        adv           = 1'b0;
        res           = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_cmd;
                    case (q_cmd.op)
                        OP_PIXEL:
                        begin
                            addr_next  = cmd_base;
                            state_next = S_PIX_RD;
                        end
                        OP_ROW:
                        begin
                            addr_next  = cmd_base;
                            col_next   = '0;
                            state_next = S_ROW_RD;
                        end
                        OP_CLEAR:
                        begin
                            addr_next     = '0;
                            clr_emit_next = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        OP_INIT:
                        begin
                            emit = 1'b1;
                            if (phase_reg == PH_IDLE)
                            begin
                                phase_next = PH_INIT;
                                off_next   = '0;
                                page_next  = '0;
                            end
                        end
                        OP_REFRESH:
                        begin
                            emit = 1'b1;
                            if (phase_reg == PH_IDLE)
                            begin
                                phase_next = PH_REFRESH;
                                off_next   = '0;
                                page_next  = '0;
                            end
                        end
                        OP_FETCH:
                        begin
                            if (phase_reg == PH_INIT)
                            begin
                                emit      = 1'b1;
                                res.valid = 1'b1;
                                res.data_byte = (off_reg[4:0] == CONTRAST_SLOT) ?
                                                contrast_reg : init_byte(off_reg[4:0]);
                                if (off_reg == LAST_INIT)
                                begin
                                    // The init stream ends by wiping the frame and
                                    // rolling straight into a refresh.
                                    phase_next    = PH_REFRESH;
                                    off_next      = '0;
                                    page_next     = '0;
                                    addr_next     = '0;
                                    clr_emit_next = 1'b0;
                                    state_next    = S_CLEAR;
                                end
                                else
                                begin
                                    off_next = off_reg + OW'(1);
                                end
                            end
                            else if (phase_reg == PH_REFRESH)
                            begin
                                if (off_reg < FIRST_DAT)
                                begin
                                    emit      = 1'b1;
                                    adv       = 1'b1;
                                    res.valid = 1'b1;
                                    if (off_reg == '0)
                                    begin
                                        res.data_byte = CMD_PAGE_BASE + 8'(page_reg);
                                    end
                                    else if (off_reg == OW'(1))
                                    begin
                                        res.data_byte = CMD_COL_LO;
                                    end
                                    else
                                    begin
                                        res.data_byte = CMD_COL_HI;
                                    end
                                end
                                else
                                begin
                                    addr_next  = AW'(int'(page_reg) * COLUMNS
                                                     + int'(off_reg) - 3);
                                    state_next = S_FETCH_RD;
                                end
                            end
                            else
                            begin
                                emit = 1'b1;
                            end
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (addr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                    boot_next  = 1'b0;
                    emit       = clr_emit_reg;
                end
                else
                begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            S_PIX_RD:
            begin
                state_next = S_PIX_WR;
            end
            S_PIX_WR:
            begin
                mem_we     = 1'b1;
                mem_wd     = cur_reg.on ? (rd_data_reg | cur_reg.mask)
                                        : (rd_data_reg & ~cur_reg.mask);
                emit       = 1'b1;
                state_next = S_IDLE;
            end
            S_ROW_RD:
            begin
                state_next = S_ROW_WR;
            end
            S_ROW_WR:
            begin
                mem_we = 1'b1;
                mem_wd = rd_data_reg | cur_reg.mask;
                if (col_reg == LAST_COL)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    col_next   = col_reg + CW'(1);
                    addr_next  = addr_reg + AW'(1);
                    state_next = S_ROW_RD;
                end
            end
            S_FETCH_RD:
            begin
                state_next = S_FETCH_WR;
            end
            S_FETCH_WR:
            begin
                emit          = 1'b1;
                adv           = 1'b1;
                res.valid     = 1'b1;
                res.is_data   = 1'b1;
                res.data_byte = rd_data_reg;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Step through the refresh stream: page command triple, then the columns.
        if (adv)
        begin
            if (off_reg == LAST_OFF)
            begin
                off_next = '0;
                if (page_reg == LAST_PAGE)
                begin
                    phase_next = PH_IDLE;
                    page_next  = '0;
                    res.last   = 1'b1;
                end
                else
                begin
                    page_next = page_reg + PW'(1);
                end
            end
            else
            begin
                off_next = off_reg + OW'(1);
            end
        end

        res.busy     = phase_next != PH_IDLE;
        m_valid_next = emit ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            addr_reg     <= '0;
            col_reg      <= '0;
            boot_reg     <= 1'b1;
            clr_emit_reg <= 1'b0;
            phase_reg    <= PH_IDLE;
            off_reg      <= '0;
            page_reg     <= '0;
            contrast_reg <= CONTRAST_RESET;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            col_reg      <= col_next;
            boot_reg     <= boot_next;
            clr_emit_reg <= clr_emit_next;
            phase_reg    <= phase_next;
            off_reg      <= off_next;
            page_reg     <= page_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid)
            begin
                contrast_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (emit)
        begin
            res_reg <= res;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[addr_reg] <= mem_wd;
        end
        rd_data_reg <= frame_mem[addr_reg];
    end

endmodule

// ===== tb/sv/mopf_tb_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard for the page-mode frame buffer: a bit-true copy of the frame store and
// byte stream, plus the queue of responses it expects. Depends on mopf_pkg.
package mopf_tb_pkg;

    import mopf_pkg::*;

    localparam int FB_COLUMNS  = 128;
    localparam int FB_PAGES    = 8;
    localparam int FB_ROWS     = FB_PAGES * 8;
    localparam int FB_BYTES    = FB_COLUMNS * FB_PAGES;
    localparam int PAGE_SPAN   = FB_COLUMNS + 3;
    localparam int REFRESH_LEN = FB_PAGES * PAGE_SPAN;

    // Action codes that the block must treat as no-ops.
    localparam logic [2:0] ACT_SPARE_A = 3'd6;
    localparam logic [2:0] ACT_SPARE_B = 3'd7;

    // Power-up command bytes, byte 0 in the lowest bits.
    localparam logic [INIT_LEN*8-1:0] POWER_UP_CMDS = {
        8'hAF, 8'hA6, 8'hA4, 8'h40, 8'hDB, 8'hF1, 8'hD9, 8'h7F, 8'h81, 8'h12,
        8'hDA, 8'hC8, 8'hA1, 8'h02, 8'h20, 8'h14, 8'h8D, 8'h40, 8'h00, 8'hD3,
        8'h3F, 8'hA8, 8'h80, 8'hD5, 8'hAE};

    class frame_scoreboard;
        logic [7:0]  frame_copy [FB_BYTES];
        logic [1:0]  phase;
        int unsigned position;
        logic [7:0]  contrast;
        res_t        awaited_responses [$];
        int unsigned error_count;
        int unsigned checked_count;

        function new();
            wipe();
            phase         = PH_IDLE;
            position      = 0;
            contrast      = CONTRAST_RESET;
            error_count   = 0;
            checked_count = 0;
        endfunction

        function void wipe();
            foreach (frame_copy[i])
            begin
                frame_copy[i] = 8'h00;
            end
        endfunction

        function void put_dot(int unsigned x, int unsigned y, logic on);
            int unsigned idx;
            if (x >= FB_COLUMNS || y >= FB_ROWS)
            begin
                return;
            end
            idx = x + (y >> 3) * FB_COLUMNS;
            if (on)
            begin
                frame_copy[idx][y % 8] = 1'b1;
            end
            else
            begin
                frame_copy[idx][y % 8] = 1'b0;
            end
        endfunction

        function void set_contrast(logic [7:0] level);
            contrast = level;
        endfunction

        function bit streaming();
            return phase != PH_IDLE;
        endfunction

        function int pending();
            return awaited_responses.size();
        endfunction

        // Applies one accepted request and queues the response it must produce.
        function void note_request(logic [2:0] action, logic [7:0] px, logic [6:0] py,
                                   logic on);
            res_t        r;
            int unsigned p;
            int unsigned pg;
            int unsigned off;
            r = '0;
            case (action)
                ACT_PIXEL:
                begin
                    put_dot(px, py, on);
                end
                ACT_CLEAR:
                begin
                    wipe();
                end
                ACT_ROW:
                begin
                    // The row line always sets, whatever pixel_on says.
                    for (int c = 0; c < FB_COLUMNS; c++)
                    begin
                        put_dot(c, py, 1'b1);
                    end
                end
                ACT_INIT:
                begin
                    if (phase == PH_IDLE)
                    begin
                        phase    = PH_INIT;
                        position = 0;
                    end
                end
                ACT_REFRESH:
                begin
                    if (phase == PH_IDLE)
                    begin
                        phase    = PH_REFRESH;
                        position = 0;
                    end
                end
                ACT_FETCH:
                begin
                    if (phase == PH_INIT)
                    begin
                        p = (position >= INIT_LEN) ? INIT_LEN - 1 : position;
                        r.data_byte = (p == CONTRAST_SLOT) ? contrast
                                                           : POWER_UP_CMDS[p*8 +: 8];
                        r.valid  = 1'b1;
                        position = p + 1;
                        // The last init byte wipes the store and chains a refresh.
                        if (position >= INIT_LEN)
                        begin
                            wipe();
                            phase    = PH_REFRESH;
                            position = 0;
                        end
                    end
                    else if (phase == PH_REFRESH)
                    begin
                        p   = (position >= REFRESH_LEN) ? REFRESH_LEN - 1 : position;
                        pg  = p / PAGE_SPAN;
                        off = p % PAGE_SPAN;
                        if (off == 0)
                        begin
                            r.data_byte = CMD_PAGE_BASE + 8'(pg);
                        end
                        else if (off == 1)
                        begin
                            r.data_byte = CMD_COL_LO;
                        end
                        else if (off == 2)
                        begin
                            r.data_byte = CMD_COL_HI;
                        end
                        else
                        begin
                            r.data_byte = frame_copy[pg * FB_COLUMNS + off - 3];
                            r.is_data   = 1'b1;
                        end
                        r.valid  = 1'b1;
                        position = p + 1;
                        if (position >= REFRESH_LEN)
                        begin
                            r.last   = 1'b1;
                            phase    = PH_IDLE;
                            position = 0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            r.busy = (phase != PH_IDLE);
            awaited_responses.push_back(r);
        endfunction

        function void check_result(res_t got);
            res_t want;
            checked_count++;
            if (awaited_responses.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                begin
                    $display("ERROR: response %0d arrived with no request pending",
                             checked_count);
                end
                return;
            end
            want = awaited_responses.pop_front();
            if (got.valid !== want.valid || got.data_byte !== want.data_byte ||
                got.is_data !== want.is_data || got.last !== want.last ||
                got.busy !== want.busy)
            begin
                error_count++;
                if (error_count <= 10)
                begin
                    $display("ERROR: response %0d expected valid=%b byte=%h data=%b last=%b busy=%b",
                             checked_count, want.valid, want.data_byte, want.is_data,
                             want.last, want.busy);
                    $display("       got      valid=%b byte=%h data=%b last=%b busy=%b",
                             got.valid, got.data_byte, got.is_data, got.last, got.busy);
                end
            end
        endfunction
    endclass

endpackage

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the frame buffer testbench: clock, reset, request driver, response monitor
// and watchdog. Depends on mopf_pkg, mopf_tb_pkg and mono_oled_page_framebuffer.
module tb_top;

    import mopf_pkg::*;
    import mopf_tb_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = 8'h00;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = 16'h0000;
    logic [2:0]  s_tuser   = ACT_PIXEL;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    frame_scoreboard sb;

    int unsigned tx_count = 0;
    int unsigned rx_count = 0;
    bit          tx_calm  = 1'b0;
    bit          rx_calm  = 1'b0;
    bit          rx_taken = 1'b0;
    bit          rx_hold  = 1'b0;
    int          rx_wait  = 0;

    always #4 clk = ~clk;

    mono_oled_page_framebuffer #(
        .COLUMNS   (FB_COLUMNS),
        .PAGE_COUNT(FB_PAGES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Offers one request after a random gap and waits until it is taken.
    task automatic send_item(input logic [2:0] act, input logic [7:0] px,
                             input logic [6:0] py, input logic on);
        int gap;
        if (tx_count % 64 == 0)
        begin
            tx_calm = ($urandom_range(0, 3) == 0);
        end
        gap = tx_calm ? 0 : $urandom_range(0, 10);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {on, py, px};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(act, px, py, on);
        tx_count++;
    endtask

    task automatic send_random();
        int         pick;
        logic [2:0] act;
        logic [7:0] px;
        logic [6:0] py;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            act = ACT_PIXEL;
        else if (pick < 35)
            act = ACT_ROW;
        else if (pick < 36)
            act = ACT_CLEAR;
        else if (pick < 39)
            act = ACT_INIT;
        else if (pick < 43)
            act = ACT_REFRESH;
        else if (pick < 45)
            act = pick[0] ? ACT_SPARE_A : ACT_SPARE_B;
        else
            act = ACT_FETCH;
        // Mostly on-screen coordinates, with a share of the full field range.
        px = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 127)) : 8'($urandom);
        py = ($urandom_range(0, 4) != 0) ? 7'($urandom_range(0, 63)) : 7'($urandom);
        send_item(act, px, py, 1'($urandom));
    endtask

    // Waits until every response is in and the block has settled.
    task automatic quiesce();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // Random requests, then, when asked, fetches until the pending stream has run out.
    task automatic run_phase(input int count, input bit drain);
        repeat (count) send_random();
        while (drain && sb.streaming())
        begin
            send_item(ACT_FETCH, 8'($urandom), 7'($urandom), 1'($urandom));
        end
        quiesce();
    endtask

    task automatic write_contrast(input logic [7:0] level);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= level;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_contrast(level);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        res_t got;
        if (m_tvalid === 1'b1 && m_tready)
        begin
            got.valid     = m_tdata[0];
            got.data_byte = m_tdata[8:1];
            got.busy      = m_tdata[9];
            got.is_data   = m_tuser;
            got.last      = m_tlast;
            sb.check_result(got);
            rx_count++;
            rx_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (rx_taken)
        begin
            rx_taken = 1'b0;
            if (rx_count % 64 == 0)
            begin
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            rx_wait = rx_calm ? 0 : $urandom_range(0, 10);
        end
        if (rx_hold || rx_wait > 0)
        begin
            m_tready <= 1'b0;
            if (rx_wait > 0)
            begin
                rx_wait--;
            end
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // One long receiver stall so the queue fills and the input backs up.
    initial
    begin
        wait (tx_count >= 120);
        @(posedge clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid === 1'b1 && m_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        sb = new();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_contrast(8'h00);

        // Fetch while idle and the unused codes.
        send_item(ACT_FETCH,   8'h5A, 7'h2B, 1'b1);
        send_item(ACT_SPARE_A, 8'hFF, 7'h7F, 1'b1);
        send_item(ACT_SPARE_B, 8'h00, 7'h00, 1'b0);
        // Corners, then requests off the panel in x, in y and in both.
        send_item(ACT_PIXEL,   8'd0,   7'd0,   1'b1);
        send_item(ACT_PIXEL,   8'd127, 7'd63,  1'b1);
        send_item(ACT_PIXEL,   8'd128, 7'd5,   1'b1);
        send_item(ACT_PIXEL,   8'd255, 7'd127, 1'b1);
        send_item(ACT_PIXEL,   8'd10,  7'd64,  1'b1);
        send_item(ACT_PIXEL,   8'd0,   7'd0,   1'b0);
        // Row lines ignore pixel_on; rows off the panel do nothing.
        send_item(ACT_ROW,     8'd77,  7'd0,   1'b0);
        send_item(ACT_ROW,     8'd255, 7'd63,  1'b1);
        send_item(ACT_ROW,     8'd3,   7'd64,  1'b1);
        send_item(ACT_ROW,     8'd0,   7'd127, 1'b1);
        send_item(ACT_PIXEL,   8'd5,   7'd0,   1'b0);
        send_item(ACT_CLEAR,   8'hA5,  7'h55,  1'b1);
        send_item(ACT_PIXEL,   8'd127, 7'd0,   1'b1);
        // Start init, then starts while busy are ignored.
        send_item(ACT_INIT,    8'd0,   7'd0,   1'b0);
        send_item(ACT_REFRESH, 8'd0,   7'd0,   1'b0);
        send_item(ACT_INIT,    8'd0,   7'd0,   1'b0);
        send_item(ACT_FETCH,   8'd0,   7'd0,   1'b0);
        send_item(ACT_FETCH,   8'd0,   7'd0,   1'b0);
        // Drawing and clearing while the stream is pending.
        send_item(ACT_PIXEL,   8'd3,   7'd7,   1'b1);
        send_item(ACT_FETCH,   8'd0,   7'd0,   1'b0);
        send_item(ACT_CLEAR,   8'd0,   7'd0,   1'b0);

        // The whole init stream and its chained refresh run out here.
        run_phase(200, 1'b1);

        // A second init passes the contrast slot and chains into a refresh.
        write_contrast(8'hFF);
        send_item(ACT_INIT, 8'd0, 7'd0, 1'b0);
        run_phase(230, 1'b0);

        // The chained refresh is still pending, so this start is ignored.
        write_contrast(8'($urandom_range(1, 254)));
        send_item(ACT_REFRESH, 8'd0, 7'd0, 1'b0);
        run_phase(230, 1'b0);

        if (sb.error_count == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
